[rtl/core/pfpf_pkg.sv]
// Shared types, codes and constants of the position fix plausibility filter.
package pfpf_pkg;

    // Field widths
    localparam int COORD_W  = 21;
    localparam int LOAD_W   = 12;
    localparam int THR_W    = 16;
    localparam int COUNT_W  = 8;
    localparam int LIM_W    = THR_W + COUNT_W;
    localparam int CFG_W    = 21;
    localparam int CFG_A_W  = 3;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 56;
    localparam int M_USER_W = 3;

    // Defaults for the top-level parameters
    localparam int IDLE_LIMIT_DEF = 200;
    localparam int Q_DEPTH_DEF    = 2;

    // Miss counter limits
    localparam logic [COUNT_W-1:0] MISS_MAX  = 8'd255;
    localparam logic [COUNT_W-1:0] MISS_INIT = 8'd1;

    typedef logic signed [COORD_W-1:0] coord_t;

    // Register indexes
    localparam logic [CFG_A_W-1:0] REG_MOVE_THRESHOLD = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_JITTER_LIMIT   = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_MAX_STEP       = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_X_LOW          = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_X_HIGH         = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_Y_LOW          = 3'd5;
    localparam logic [CFG_A_W-1:0] REG_Y_HIGH         = 3'd6;
    localparam logic [CFG_A_W-1:0] REG_ZONE_SPLIT_Y   = 3'd7;

    // Register reset values
    localparam logic [THR_W-1:0] MOVE_THRESHOLD_RST = 16'd350;
    localparam logic [THR_W-1:0] JITTER_LIMIT_RST   = 16'd400;
    localparam logic [THR_W-1:0] MAX_STEP_RST       = 16'd1000;
    localparam coord_t           X_LOW_RST          = 21'sd0;
    localparam coord_t           X_HIGH_RST         = 21'sd21860;
    localparam coord_t           Y_LOW_RST          = 21'sd0;
    localparam coord_t           Y_HIGH_RST         = 21'sd45600;
    localparam coord_t           ZONE_SPLIT_Y_RST   = 21'sd30400;

    typedef enum logic [2:0] {
        VERDICT_REPORT = 3'd0,
        VERDICT_IDLE   = 3'd1,
        VERDICT_JUMP   = 3'd2,
        VERDICT_OOB    = 3'd3,
        VERDICT_FAIL   = 3'd4
    } verdict_t;

    typedef enum logic [1:0] {
        SWITCH_NONE  = 2'd0,
        SWITCH_UPPER = 2'd1,
        SWITCH_LOWER = 2'd2
    } switch_t;

    typedef struct packed {
        logic [THR_W-1:0] move_threshold;
        logic [THR_W-1:0] jitter_limit;
        logic [THR_W-1:0] max_step;
        coord_t           x_low;
        coord_t           x_high;
        coord_t           y_low;
        coord_t           y_high;
        coord_t           zone_split_y;
    } cfg_t;

    // One classified request between front and back
    typedef struct packed {
        logic              fix_ok;
        coord_t            pos_x;
        coord_t            pos_y;
        logic [LOAD_W-1:0] load;
        logic              in_box;
        logic              above_split;
    } entry_t;

    typedef struct packed {
        verdict_t          verdict;
        coord_t            out_x;
        coord_t            out_y;
        logic [LOAD_W-1:0] out_load;
        switch_t           anchor_switch;
    } result_t;

endpackage

[rtl/core/position_fix_plausibility_filter_top.sv]
// Top level of the position fix plausibility filter: ports, registers and stage wiring.
//
// Every accepted fix request yields exactly one verdict, in order. A request passes
// through the front classification register, the queue and the back output register;
// one request is accepted every cycle while the result side does not stall; throughput
// is set by the back stage, which updates the filter state for one request per cycle.
// The queue of Q_DEPTH entries lets the input keep flowing for a while when the
// result side stalls. Register writes are meant for an idle block.
module position_fix_plausibility_filter_top #(
    parameter int IDLE_LIMIT = pfpf_pkg::IDLE_LIMIT_DEF,
    parameter int Q_DEPTH    = pfpf_pkg::Q_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port
    input  logic                            cfg_we,
    input  logic [pfpf_pkg::CFG_A_W-1:0]    cfg_addr,
    input  logic [pfpf_pkg::CFG_W-1:0]      cfg_wdata,
    // Fix requests
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [20:0] pos_x, [41:21] pos_y, [53:42] load_sample, [55:54] zero
    input  logic [pfpf_pkg::S_DATA_W-1:0]   s_tdata,
    // [0] fix_ok
    input  logic                            s_tuser,
    // Verdicts
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [20:0] out_x, [41:21] out_y, [53:42] out_load, [55:54] anchor_switch
    output logic [pfpf_pkg::M_DATA_W-1:0]   m_tdata,
    // [2:0] verdict
    output logic [pfpf_pkg::M_USER_W-1:0]   m_tuser
);

    localparam int CW = pfpf_pkg::COORD_W;
    localparam int LW = pfpf_pkg::LOAD_W;
    localparam int TW = pfpf_pkg::THR_W;

    pfpf_pkg::cfg_t    cfg_reg;
    logic              fq_valid;
    logic              fq_ready;
    pfpf_pkg::entry_t  fq_entry;
    logic              qb_valid;
    logic              qb_ready;
    pfpf_pkg::entry_t  qb_entry;
    pfpf_pkg::result_t result;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.move_threshold <= pfpf_pkg::MOVE_THRESHOLD_RST;
            cfg_reg.jitter_limit   <= pfpf_pkg::JITTER_LIMIT_RST;
            cfg_reg.max_step       <= pfpf_pkg::MAX_STEP_RST;
            cfg_reg.x_low          <= pfpf_pkg::X_LOW_RST;
            cfg_reg.x_high         <= pfpf_pkg::X_HIGH_RST;
            cfg_reg.y_low          <= pfpf_pkg::Y_LOW_RST;
            cfg_reg.y_high         <= pfpf_pkg::Y_HIGH_RST;
            cfg_reg.zone_split_y   <= pfpf_pkg::ZONE_SPLIT_Y_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                pfpf_pkg::REG_MOVE_THRESHOLD: cfg_reg.move_threshold <= cfg_wdata[TW-1:0];
                pfpf_pkg::REG_JITTER_LIMIT:   cfg_reg.jitter_limit   <= cfg_wdata[TW-1:0];
                pfpf_pkg::REG_MAX_STEP:       cfg_reg.max_step       <= cfg_wdata[TW-1:0];
                pfpf_pkg::REG_X_LOW:          cfg_reg.x_low          <= cfg_wdata;
                pfpf_pkg::REG_X_HIGH:         cfg_reg.x_high         <= cfg_wdata;
                pfpf_pkg::REG_Y_LOW:          cfg_reg.y_low          <= cfg_wdata;
                pfpf_pkg::REG_Y_HIGH:         cfg_reg.y_high         <= cfg_wdata;
                pfpf_pkg::REG_ZONE_SPLIT_Y:   cfg_reg.zone_split_y   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    pfpf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_fix_ok (s_tuser),
        .in_x      (s_tdata[CW-1:0]),
        .in_y      (s_tdata[2*CW-1:CW]),
        .in_load   (s_tdata[2*CW+LW-1:2*CW]),
        .out_valid (fq_valid),
        .out_ready (fq_ready),
        .out_entry (fq_entry)
    );

    pfpf_queue #(
        .Q_DEPTH (Q_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_entry  (fq_entry),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_entry (qb_entry)
    );

    pfpf_back #(
        .IDLE_LIMIT (IDLE_LIMIT)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (qb_valid),
        .in_ready   (qb_ready),
        .in_entry   (qb_entry),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // Pack the verdict onto the master side
    assign m_tdata = {result.anchor_switch, result.out_load, result.out_y, result.out_x};
    assign m_tuser = result.verdict;

endmodule

[rtl/core/pfpf_front.sv]
// Front stage: accept a fix request and classify it against the box and split line.
module pfpf_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  pfpf_pkg::cfg_t  cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            in_fix_ok,
    input  pfpf_pkg::coord_t in_x,
    input  pfpf_pkg::coord_t in_y,
    input  logic [pfpf_pkg::LOAD_W-1:0] in_load,
    output logic            out_valid,
    input  logic            out_ready,
    output pfpf_pkg::entry_t out_entry
);

    logic             valid_reg;
    pfpf_pkg::entry_t entry_reg;
    pfpf_pkg::entry_t entry_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_entry = entry_reg;

    // Classify the incoming fix; these checks need no filter state
    always_comb begin
        entry_next.fix_ok      = in_fix_ok;
        entry_next.pos_x       = in_x;
        entry_next.pos_y       = in_y;
        entry_next.load        = in_load;
        entry_next.in_box      = (in_x <= cfg.x_high) && (in_x >= cfg.x_low) &&
                                 (in_y <= cfg.y_high) && (in_y >= cfg.y_low);
        entry_next.above_split = (in_y >= cfg.zone_split_y);
    end

    // Hold the classified request until the queue takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            entry_reg <= entry_next;
        end
    end

endmodule

[rtl/core/pfpf_queue.sv]
// Short FIFO that decouples the front stage from the back stage.
module pfpf_queue #(
    parameter int Q_DEPTH = pfpf_pkg::Q_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  pfpf_pkg::entry_t in_entry,
    output logic             out_valid,
    input  logic             out_ready,
    output pfpf_pkg::entry_t out_entry
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(Q_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(Q_DEPTH);

    pfpf_pkg::entry_t   slot_reg [Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               push;
    logic               pop;

    assign in_ready  = (count_reg != CNT_FULL);
    assign out_valid = (count_reg != '0);
    assign out_entry = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store the pushed request
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

[rtl/core/pfpf_back.sv]
// Back stage: track filter state, decide the verdict and hold it in the output register.
module pfpf_back #(
    parameter int IDLE_LIMIT = pfpf_pkg::IDLE_LIMIT_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  pfpf_pkg::cfg_t    cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  pfpf_pkg::entry_t  in_entry,
    output logic              out_valid,
    input  logic              out_ready,
    output pfpf_pkg::result_t out_result
);

    localparam int CW = pfpf_pkg::COORD_W;
    localparam logic [pfpf_pkg::COUNT_W-1:0] IDLE_LIM = pfpf_pkg::COUNT_W'(IDLE_LIMIT);

    // Filter state
    pfpf_pkg::coord_t               prev_x_reg;
    pfpf_pkg::coord_t               prev_y_reg;
    logic                           seeded_reg;
    logic [pfpf_pkg::COUNT_W-1:0]   miss_reg;
    logic [pfpf_pkg::COUNT_W-1:0]   still_reg;
    logic                           upper_reg;

    pfpf_pkg::coord_t               prev_x_next;
    pfpf_pkg::coord_t               prev_y_next;
    logic                           seeded_next;
    logic [pfpf_pkg::COUNT_W-1:0]   miss_next;
    logic [pfpf_pkg::COUNT_W-1:0]   still_next;
    logic                           upper_next;

    // Output register
    logic                           valid_reg;
    pfpf_pkg::result_t              result_reg;
    pfpf_pkg::result_t              result_next;

    logic signed [CW:0]             diff_x;
    logic signed [CW:0]             diff_y;
    logic [CW-1:0]                  dx;
    logic [CW-1:0]                  dy;
    logic [pfpf_pkg::LIM_W-1:0]     jump_lim;
    logic [pfpf_pkg::COUNT_W-1:0]   still_inc;
    logic [pfpf_pkg::COUNT_W-1:0]   miss_inc;
    logic                           moved;
    logic                           jitter;
    logic                           jump;
    logic                           oob;
    logic                           take;

    assign in_ready   = !valid_reg || out_ready;
    assign take       = in_valid && in_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    // Per-axis distance to the previous position and jump limit
    always_comb begin
        diff_x   = {in_entry.pos_x[CW-1], in_entry.pos_x} - {prev_x_reg[CW-1], prev_x_reg};
        diff_y   = {in_entry.pos_y[CW-1], in_entry.pos_y} - {prev_y_reg[CW-1], prev_y_reg};
        dx       = diff_x[CW] ? CW'(-diff_x) : diff_x[CW-1:0];
        dy       = diff_y[CW] ? CW'(-diff_y) : diff_y[CW-1:0];
        jump_lim = cfg.max_step * miss_reg;
        moved    = (dx >= CW'(cfg.move_threshold)) || (dy >= CW'(cfg.move_threshold));
        jitter   = (dx < CW'(cfg.jitter_limit)) && (dy < CW'(cfg.jitter_limit));
        jump     = moved && ((pfpf_pkg::LIM_W'(dx) > jump_lim) ||
                             (pfpf_pkg::LIM_W'(dy) > jump_lim));
        oob      = moved && !jump && !in_entry.in_box;
        still_inc = (still_reg < IDLE_LIM) ? still_reg + 1'b1 : still_reg;
        miss_inc  = (miss_reg < pfpf_pkg::MISS_MAX) ? miss_reg + 1'b1 : miss_reg;
    end

    // Decide the verdict and the next filter state
    always_comb begin
        prev_x_next = prev_x_reg;
        prev_y_next = prev_y_reg;
        seeded_next = seeded_reg;
        miss_next   = miss_reg;
        still_next  = still_reg;
        upper_next  = upper_reg;

        result_next.verdict       = pfpf_pkg::VERDICT_FAIL;
        result_next.out_x         = '0;
        result_next.out_y         = '0;
        result_next.out_load      = '0;
        result_next.anchor_switch = pfpf_pkg::SWITCH_NONE;

        if (in_entry.fix_ok) begin
            result_next.out_x = in_entry.pos_x;
            result_next.out_y = in_entry.pos_y;
            if (!seeded_reg) begin
                // First good fix: seed the previous position only
                seeded_next          = 1'b1;
                prev_x_next          = in_entry.pos_x;
                prev_y_next          = in_entry.pos_y;
                result_next.verdict  = pfpf_pkg::VERDICT_REPORT;
                result_next.out_load = in_entry.load;
            end else begin
                if (moved && !jitter) begin
                    still_next = '0;
                end else begin
                    still_next = still_inc;
                end
                if (jump) begin
                    miss_next           = miss_inc;
                    result_next.verdict = pfpf_pkg::VERDICT_JUMP;
                end else if (oob) begin
                    miss_next           = miss_inc;
                    prev_x_next         = in_entry.pos_x;
                    prev_y_next         = in_entry.pos_y;
                    result_next.verdict = pfpf_pkg::VERDICT_OOB;
                end else begin
                    if (in_entry.above_split && !upper_reg) begin
                        upper_next                = 1'b1;
                        result_next.anchor_switch = pfpf_pkg::SWITCH_UPPER;
                    end else if (!in_entry.above_split && upper_reg) begin
                        upper_next                = 1'b0;
                        result_next.anchor_switch = pfpf_pkg::SWITCH_LOWER;
                    end
                    if (still_next >= IDLE_LIM) begin
                        result_next.verdict = pfpf_pkg::VERDICT_IDLE;
                    end else begin
                        result_next.verdict  = pfpf_pkg::VERDICT_REPORT;
                        result_next.out_load = in_entry.load;
                    end
                    prev_x_next = in_entry.pos_x;
                    prev_y_next = in_entry.pos_y;
                    miss_next   = pfpf_pkg::MISS_INIT;
                end
            end
        end
    end

    // Update filter state on each taken request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            seeded_reg <= 1'b0;
            miss_reg   <= pfpf_pkg::MISS_INIT;
            still_reg  <= '0;
            upper_reg  <= 1'b1;
        end else if (take) begin
            prev_x_reg <= prev_x_next;
            prev_y_reg <= prev_y_next;
            seeded_reg <= seeded_next;
            miss_reg   <= miss_next;
            still_reg  <= still_next;
            upper_reg  <= upper_next;
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            result_reg <= result_next;
        end
    end

endmodule

[rtl/core/pfpf_checker.sv]
// Port-level checker of the position fix plausibility filter, bound to the top level.
module pfpf_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pfpf_pkg::M_DATA_W-1:0]   m_tdata,
    input logic [pfpf_pkg::M_USER_W-1:0]   m_tuser
);

    // Stalled verdict holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled verdict changed");

    // Failed fix carries an all-zero payload
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == pfpf_pkg::VERDICT_FAIL) |-> (m_tdata == '0))
        else $error("failed fix has nonzero payload");

    // Anchor switch only on an accepted fix
    a_switch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[55:54] != pfpf_pkg::SWITCH_NONE) |->
            ((m_tuser == pfpf_pkg::VERDICT_REPORT) || (m_tuser == pfpf_pkg::VERDICT_IDLE)) &&
            (m_tdata[55:54] != 2'd3))
        else $error("anchor switch on a rejected fix");

    // Load travels only with a position report
    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[53:42] != '0) |-> (m_tuser == pfpf_pkg::VERDICT_REPORT))
        else $error("load sample outside a position report");

endmodule

bind position_fix_plausibility_filter_top pfpf_checker u_pfpf_checker (.*);
